// ----- src/sha1he_pkg.sv -----
// Shared types, constants and round functions for the SHA-1 hash engine.
// No dependencies; used by sha1he_core and sha1_hash_engine.

package sha1he_pkg;

  localparam int NUM_WORDS = 5;
  localparam int SCHED_LEN = 16;
  localparam int NUM_ROUNDS = 80;

  localparam logic [5:0] LAST_BYTE = 6'd63;
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [2:0] LAST_INDEX = 3'd4;
  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef logic [NUM_WORDS-1:0][31:0] chain_t;

  localparam chain_t CHAIN_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  // Requests from the sequencer to the compression unit.
  typedef struct packed {
    logic       shift;
    logic [7:0] data;
    logic       load;
    logic       round;
    logic       fold;
    logic       init;
    logic [6:0] rnd;
  } ctl_t;

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] k;
    if (rnd < 7'd20) begin
      k = 32'h5A827999;
    end else if (rnd < 7'd40) begin
      k = 32'h6ED9EBA1;
    end else if (rnd < 7'd60) begin
      k = 32'h8F1BBCDC;
    end else begin
      k = 32'hCA62C1D6;
    end
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

// ----- src/sha1he_core.sv -----
// SHA-1 compression unit: 16-word block/schedule shift line, working
// registers, one shared round adder and the chaining words. Uses sha1he_pkg.

module sha1he_core
  import sha1he_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  ctl_t   ctl,
  output chain_t chain
);

  logic [SCHED_LEN-1:0][31:0] w;
  logic [31:0] a, b, c, d, e;
  logic [31:0] w_new;
  logic [31:0] w_mix;
  logic [31:0] t_sum;

  // Word 0 of the line is always the word of the current round.
  assign w_mix = w[13] ^ w[8] ^ w[2] ^ w[0];
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign t_sum = {a[26:0], a[31:27]} + round_f(ctl.rnd, b, c, d) + e
               + round_k(ctl.rnd) + w[0];

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      // Bytes enter at the low end, so the first byte ends up at the top of word 0.
      for (int i = 0; i < SCHED_LEN - 1; i++) begin
        w[i] <= {w[i][23:0], w[i+1][31:24]};
      end
      w[SCHED_LEN-1] <= {w[SCHED_LEN-1][23:0], ctl.data};
    end else if (ctl.round) begin
      for (int i = 0; i < SCHED_LEN - 1; i++) begin
        w[i] <= w[i+1];
      end
      w[SCHED_LEN-1] <= w_new;
    end

    if (ctl.load) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (ctl.round) begin
      a <= t_sum;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.init) begin
      chain <= CHAIN_INIT;
    end else if (ctl.fold) begin
      chain[0] <= chain[0] + a;
      chain[1] <= chain[1] + b;
      chain[2] <= chain[2] + c;
      chain[3] <= chain[3] + d;
      chain[4] <= chain[4] + e;
    end
  end

endmodule

// ----- src/sha1_hash_engine.sv -----
// Top level of the SHA-1 hash engine: byte intake, padding sequencer and
// digest output. Uses sha1he_pkg and sha1he_core.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------
//   in      | in_valid / in_ready  | command, data_byte
//   out     | out_valid/ out_ready | digest_word, word_index, last_word
//
// An absorb request shifts one byte in; the request that completes a 64-byte
// block is followed by the 80 rounds on the shared round adder and one fold.
// A finish request pads the block up to its last byte, runs the rounds and the fold, and
// pads and runs one more block when the fill was 56 or more, then shows the five words.
// in_ready is high only while the engine idles; a stalled output holds its word.
// Reset (synchronous) loads the initial chaining words and clears count and fill.

module sha1_hash_engine
  import sha1he_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_FOLD  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]  state;
  logic [5:0]  fill;
  logic [63:0] message_bits;
  logic        fin;
  logic        len_ok;
  logic        pad_first;
  logic [6:0]  rnd;
  logic [2:0]  widx;
  logic [63:0] len_shifted;
  logic [7:0]  pad_byte;
  logic        absorb;
  ctl_t        ctl;
  chain_t      chain;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign absorb    = in_valid && in_ready && (command == CMD_ABSORB);

  // The length goes out most significant byte first at positions 56 to 63.
  assign len_shifted = message_bits >> {~fill[2:0], 3'b000};

  always_comb begin
    if (pad_first) begin
      pad_byte = PAD_MARK;
    end else if (len_ok && (fill >= LEN_POS)) begin
      pad_byte = len_shifted[7:0];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    ctl.shift = absorb || (state == S_PAD);
    ctl.data  = (state == S_PAD) ? pad_byte : data_byte;
    ctl.load  = ctl.shift && (fill == LAST_BYTE);
    ctl.round = (state == S_ROUND);
    ctl.fold  = (state == S_FOLD);
    ctl.init  = out_valid && out_ready && (widx == LAST_INDEX);
    ctl.rnd   = rnd;
  end

  sha1he_core u_core (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .chain (chain)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill         <= '0;
      message_bits <= '0;
      fin          <= 1'b0;
      len_ok       <= 1'b0;
      pad_first    <= 1'b0;
      rnd          <= '0;
      widx         <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (command == CMD_ABSORB) begin
              message_bits <= message_bits + 64'd8;
              fill         <= fill + 6'd1;
              if (fill == LAST_BYTE) begin
                state <= S_ROUND;
                rnd   <= '0;
              end
            end else begin
              fin       <= 1'b1;
              len_ok    <= (fill < LEN_POS);
              pad_first <= 1'b1;
              state     <= S_PAD;
            end
          end
        end
        S_PAD: begin
          pad_first <= 1'b0;
          fill      <= fill + 6'd1;
          if (fill == LAST_BYTE) begin
            state <= S_ROUND;
            rnd   <= '0;
          end
        end
        S_ROUND: begin
          rnd <= rnd + 7'd1;
          if (rnd == LAST_ROUND) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          if (!fin) begin
            state <= S_IDLE;
          end else if (len_ok) begin
            state <= S_OUT;
            widx  <= '0;
          end else begin
            // The marker did not leave room for the length, so pad one more block.
            len_ok <= 1'b1;
            state  <= S_PAD;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            if (widx == LAST_INDEX) begin
              state        <= S_IDLE;
              fin          <= 1'b0;
              message_bits <= '0;
            end else begin
              widx <= widx + 3'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    case (widx)
      3'd0:    digest_word = chain[0];
      3'd1:    digest_word = chain[1];
      3'd2:    digest_word = chain[2];
      3'd3:    digest_word = chain[3];
      3'd4:    digest_word = chain[4];
      default: digest_word = chain[0];
    endcase
  end

  assign word_index = widx;
  assign last_word  = (widx == LAST_INDEX);

  a_out_block_aligned: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fill == 6'd0))
    else $error("digest shown while the block buffer is partly filled");

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> (rnd <= LAST_ROUND))
    else $error("round counter ran past the last round");

  a_out_after_finish: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fin && len_ok))
    else $error("digest shown without a finished padding pass");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_word) |=> (in_ready && (message_bits == 64'd0)))
    else $error("engine did not restart after the last digest word");

endmodule
